### sv/ier_pkg.sv
// Shared types, frame offsets and ones'-complement helper for the ICMP echo responder.
package ier_pkg;

  // Frame offsets (20-byte IP header assumed)
  localparam int OFS_ETH_END      = 11;  // last byte of Ethernet source address
  localparam int OFS_IP_START     = 14;
  localparam int OFS_TL_HI        = 16;
  localparam int OFS_TL_LO        = 17;
  localparam int OFS_TTL          = 22;
  localparam int OFS_CSUM_HI      = 24;
  localparam int OFS_CSUM_LO      = 25;
  localparam int OFS_IP_END       = 33;  // last byte of IP destination address
  localparam int OFS_ICMP         = 34;
  localparam int OFS_ICMP_HDR_END = 37;  // last byte of ICMP checksum

  localparam int MAC_BYTES       = 6;
  localparam int IP_ADDR_BYTES   = 4;
  localparam int ETH_HDR_BYTES   = 14;
  localparam int IP_HDR_BYTES    = 20;
  localparam int MIN_TOTAL_LEN   = 28;

  localparam logic [7:0]  ICMP_ECHO_REQUEST = 8'h08;
  localparam logic [7:0]  TTL_RESET         = 8'd64;
  localparam logic [15:0] SUM_GOOD          = 16'hFFFF;

  typedef enum logic [1:0] {
    VD_REPLY    = 2'd0,
    VD_BAD_CSUM = 2'd1,
    VD_NOT_ECHO = 2'd2,
    VD_SHORT    = 2'd3
  } verdict_t;

  typedef enum logic {
    ST_PASS  = 1'b0,
    ST_DRAIN = 1'b1
  } ier_state_t;

  // Per-byte control from the parser to the delay line
  typedef struct packed {
    logic [7:0]  stored;    // byte to push (TTL already replaced)
    logic [15:0] ip_csum;   // recomputed IP header checksum
    verdict_t    verdict;   // frame verdict, meaningful on the last byte
    logic        eth_swap;
    logic        ip_fix;
    logic        icmp_fix;
    logic        emit;      // line is full, the oldest byte leaves
  } ier_ctl_t;

  typedef struct packed {
    verdict_t   verdict;
    logic       keep;
    logic       last;
    logic [7:0] data;
  } ier_res_t;

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

### sv/ier_parse.sv
// Header parser: byte offset, length capture, header and ICMP checksums, verdict.
module ier_parse #(
  parameter int MAX_FRAME_BYTES = 2048,
  parameter int DELAY_BYTES     = 38
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             acc,
  input  logic [7:0]                       frame_byte,
  input  logic                             frame_last,
  input  logic [7:0]                       reply_ttl,
  output ier_pkg::ier_ctl_t                ctl,
  output logic [$clog2(DELAY_BYTES)-1:0]   fill_m1
);
  import ier_pkg::*;

  localparam int OW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int IW = $clog2(DELAY_BYTES);

  logic [OW-1:0] ofs_r, ofs_nxt;
  logic [15:0]   hdr_r, hdr_nxt;
  logic [15:0]   icmp_r, icmp_nxt;
  logic [15:0]   tl_r, tl_nxt;
  logic          echo_r, echo_nxt;

  logic          counted;
  logic [7:0]    stored;
  logic          hdr_hit, icmp_hit, too_short;
  logic [15:0]   hdr_word, icmp_word;
  logic [16:0]   ofs_ext, icmp_end, rcv_ext, need_len;

  always_comb begin
    counted  = ofs_r < OW'(MAX_FRAME_BYTES);
    stored   = (ofs_r == OW'(OFS_TTL)) ? reply_ttl : frame_byte;
    ofs_ext  = 17'(ofs_r);

    // IP header sum skips the checksum field
    hdr_hit  = counted && ofs_r >= OW'(OFS_IP_START) && ofs_r <= OW'(OFS_IP_END) &&
               ofs_r != OW'(OFS_CSUM_HI) && ofs_r != OW'(OFS_CSUM_LO);
    hdr_word = ofs_r[0] ? {8'h00, stored} : {stored, 8'h00};

    // ICMP sum covers IP length - 20 bytes from offset 34
    icmp_end  = {1'b0, tl_r} + 17'(ETH_HDR_BYTES);
    icmp_hit  = counted && ofs_r >= OW'(OFS_ICMP) && tl_r >= 16'(IP_HDR_BYTES) &&
                ofs_ext < icmp_end;
    icmp_word = ofs_r[0] ? {8'h00, frame_byte} : {frame_byte, 8'h00};

    tl_nxt = tl_r;
    if (counted && ofs_r == OW'(OFS_TL_HI)) begin
      tl_nxt = {frame_byte, 8'h00};
    end
    if (counted && ofs_r == OW'(OFS_TL_LO)) begin
      tl_nxt = tl_r | {8'h00, frame_byte};
    end

    hdr_nxt  = hdr_hit  ? oc_add(hdr_r, hdr_word)   : hdr_r;
    icmp_nxt = icmp_hit ? oc_add(icmp_r, icmp_word) : icmp_r;
    echo_nxt = (counted && ofs_r == OW'(OFS_ICMP)) ? (frame_byte == ICMP_ECHO_REQUEST)
                                                   : echo_r;
    ofs_nxt  = counted ? ofs_r + OW'(1) : ofs_r;

    // Verdict from the state as it stands after this byte
    rcv_ext   = 17'(ofs_nxt);
    need_len  = {1'b0, tl_nxt} + 17'(ETH_HDR_BYTES);
    too_short = (tl_nxt < 16'(MIN_TOTAL_LEN)) || (rcv_ext < need_len);

    ctl.stored   = stored;
    ctl.ip_csum  = ~hdr_nxt;
    ctl.eth_swap = ofs_r == OW'(OFS_ETH_END);
    ctl.ip_fix   = ofs_r == OW'(OFS_IP_END);
    ctl.icmp_fix = ofs_r == OW'(OFS_ICMP_HDR_END);
    ctl.emit     = ofs_r >= OW'(DELAY_BYTES);
    if (too_short) begin
      ctl.verdict = VD_SHORT;
    end else if (icmp_nxt != SUM_GOOD) begin
      ctl.verdict = VD_BAD_CSUM;
    end else if (!echo_nxt) begin
      ctl.verdict = VD_NOT_ECHO;
    end else begin
      ctl.verdict = VD_REPLY;
    end

    // bytes held in the line minus one; short frames never wrapped
    fill_m1 = (ofs_nxt >= OW'(DELAY_BYTES)) ? IW'(DELAY_BYTES - 1) : ofs_r[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (acc && frame_last)) begin
      ofs_r  <= '0;
      hdr_r  <= '0;
      icmp_r <= '0;
      tl_r   <= '0;
      echo_r <= 1'b0;
    end else if (acc) begin
      ofs_r  <= ofs_nxt;
      hdr_r  <= hdr_nxt;
      icmp_r <= icmp_nxt;
      tl_r   <= tl_nxt;
      echo_r <= echo_nxt;
    end
  end

endmodule

### sv/ier_delay.sv
// Byte delay line with in-place header rewrites and end-of-frame drain sequencer.
module ier_delay #(
  parameter int DELAY_BYTES = 38
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             acc,
  input  logic                             frame_last,
  input  ier_pkg::ier_ctl_t                ctl,
  input  logic [$clog2(DELAY_BYTES)-1:0]   fill_m1,
  output logic                             in_ready,
  input  logic                             res_ready,
  output logic                             res_valid,
  output ier_pkg::ier_res_t                res
);
  import ier_pkg::*;

  localparam int IW       = $clog2(DELAY_BYTES);
  // positions of rewritten fields, counted back from the newest byte
  localparam int POS_CSUM = OFS_IP_END - OFS_CSUM_HI;

  logic [7:0]  dl_r  [DELAY_BYTES];
  logic [7:0]  dl_nxt[DELAY_BYTES];
  logic [7:0]  sh    [DELAY_BYTES];

  ier_state_t  state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  verdict_t    verdict_r, verdict_nxt;
  logic [IW-1:0] rd_idx;
  logic [15:0] icmp_csum;
  logic        fin;

  // shift in, then rewrite fields whose last byte just arrived
  always_comb begin
    sh[0] = ctl.stored;
    for (int i = 1; i < DELAY_BYTES; i++) begin
      sh[i] = dl_r[i-1];
    end
    icmp_csum = ~oc_add(~{sh[1], sh[0]}, ~{sh[3], sh[2]});
    dl_nxt = sh;
    if (ctl.eth_swap) begin
      for (int k = 0; k < MAC_BYTES; k++) begin
        dl_nxt[k]             = sh[k + MAC_BYTES];
        dl_nxt[k + MAC_BYTES] = sh[k];
      end
    end
    if (ctl.ip_fix) begin
      for (int k = 0; k < IP_ADDR_BYTES; k++) begin
        dl_nxt[k]                 = sh[k + IP_ADDR_BYTES];
        dl_nxt[k + IP_ADDR_BYTES] = sh[k];
      end
      dl_nxt[POS_CSUM]     = ctl.ip_csum[15:8];
      dl_nxt[POS_CSUM - 1] = ctl.ip_csum[7:0];
    end
    if (ctl.icmp_fix) begin
      dl_nxt[3] = 8'h00;  // type
      dl_nxt[2] = 8'h00;  // code
      dl_nxt[1] = icmp_csum[15:8];
      dl_nxt[0] = icmp_csum[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      dl_r <= dl_nxt;
    end
  end

  // result selection and drain sequencing
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    verdict_nxt = verdict_r;
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    fin         = 1'b0;
    rd_idx      = IW'(DELAY_BYTES - 1);
    unique case (state_r)
      ST_PASS: begin
        // nothing is taken while reset is held
        in_ready  = res_ready && rst_n;
        res_valid = acc && ctl.emit;
        if (acc && frame_last) begin
          state_nxt   = ST_DRAIN;
          idx_nxt     = fill_m1;
          verdict_nxt = ctl.verdict;
        end
      end
      ST_DRAIN: begin
        rd_idx    = idx_r;
        res_valid = 1'b1;
        fin       = idx_r == '0;
        if (res_ready) begin
          if (fin) begin
            state_nxt = ST_PASS;
          end else begin
            idx_nxt = idx_r - IW'(1);
          end
        end
      end
      default: state_nxt = ST_PASS;
    endcase
    res.data    = dl_r[rd_idx];
    res.last    = fin;
    res.keep    = fin && (verdict_r == VD_REPLY);
    res.verdict = fin ? verdict_r : VD_REPLY;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_PASS;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    verdict_r <= verdict_nxt;
  end

endmodule

### sv/ier_skid.sv
// Two-entry output stage: result register plus skid register.
module ier_skid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s_valid,
  input  ier_pkg::ier_res_t s_data,
  output logic              s_ready,
  output logic              m_valid,
  output ier_pkg::ier_res_t m_data,
  input  logic              m_ready
);
  import ier_pkg::*;

  logic     out_v_r, out_v_nxt;
  logic     skid_v_r, skid_v_nxt;
  ier_res_t out_r, out_nxt;
  ier_res_t skid_r, skid_nxt;
  logic     push;

  assign s_ready = !skid_v_r;
  assign push    = s_valid && !skid_v_r;
  assign m_valid = out_v_r;
  assign m_data  = out_r;

  always_comb begin
    out_v_nxt  = out_v_r;
    out_nxt    = out_r;
    skid_v_nxt = skid_v_r;
    skid_nxt   = skid_r;
    if (!out_v_r || m_ready) begin
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        out_nxt    = skid_r;
        skid_v_nxt = 1'b0;
      end else begin
        out_v_nxt = push;
        out_nxt   = s_data;
      end
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_nxt   = s_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

endmodule

### sv/icmp_echo_responder.sv
// Top level: ICMP echo request to echo reply byte-stream rewriter.
//
//  channel  dir  handshake          payload
//  in_      in   in_tvalid/tready   in_tdata[7:0] frame byte, in_tlast end of frame
//  out_     out  out_tvalid/tready  out_tdata[7:0] reply byte, out_tlast end of frame,
//                                   out_tuser[0] keep, out_tuser[2:1] verdict
//  cfg_     in   cfg_we             cfg_wdata[7:0] reply TTL
//
//  One request byte per cycle while in_tready is high; each byte taken, once the line holds
//  DELAY_BYTES bytes, pushes the oldest byte out. After the last byte the line drains
//  min(frame bytes, DELAY_BYTES) bytes; in_tready is low while it drains.
//  Output back-pressure is absorbed by a result register plus a skid register.
//  rst_n is synchronous, active low; reply TTL resets to 64.
module icmp_echo_responder #(
  parameter int MAX_FRAME_BYTES = 2048,
  parameter int DELAY_BYTES     = 38
) (
  input  logic       clk,
  input  logic       rst_n,
  // request stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] frame_byte
  input  logic       in_tlast,   // frame_last
  // reply stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,  // out_last
  output logic [2:0] out_tuser,  // [0] keep_frame, [2:1] verdict
  // configuration
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata   // [7:0] reply_ttl
);
  import ier_pkg::*;

  localparam int IW = $clog2(DELAY_BYTES);

  logic [7:0]    reply_ttl_r;
  logic          acc;
  ier_ctl_t      ctl;
  logic [IW-1:0] fill_m1;
  logic          res_valid, res_ready;
  ier_res_t      res, out_res;

  // reply TTL register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reply_ttl_r <= TTL_RESET;
    end else if (cfg_we) begin
      reply_ttl_r <= cfg_wdata;
    end
  end

  assign acc = in_tvalid && in_tready;

  ier_parse #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
    .DELAY_BYTES     (DELAY_BYTES)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .frame_byte (in_tdata),
    .frame_last (in_tlast),
    .reply_ttl  (reply_ttl_r),
    .ctl        (ctl),
    .fill_m1    (fill_m1)
  );

  ier_delay #(
    .DELAY_BYTES (DELAY_BYTES)
  ) u_delay (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .frame_last (in_tlast),
    .ctl        (ctl),
    .fill_m1    (fill_m1),
    .in_ready   (in_tready),
    .res_ready  (res_ready),
    .res_valid  (res_valid),
    .res        (res)
  );

  ier_skid u_skid (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (res_valid),
    .s_data  (res),
    .s_ready (res_ready),
    .m_valid (out_tvalid),
    .m_data  (out_res),
    .m_ready (out_tready)
  );

  assign out_tdata = out_res.data;
  assign out_tlast = out_res.last;
  assign out_tuser = {out_res.verdict, out_res.keep};

`ifndef SYNTHESIS
  a_drain_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> !in_tready)
    else $error("request accepted right after end of frame");

  a_mid_frame_flags_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_tuser == 3'd0))
    else $error("keep/verdict set on a non-final reply byte");

  a_keep_means_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tlast && out_tuser[2:1] == VD_REPLY))
    else $error("keep set without reply verdict on final byte");

  a_ttl_written: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (reply_ttl_r == $past(cfg_wdata)))
    else $error("reply TTL not updated by configuration write");
`endif

endmodule

### test/icmp_echo_responder_chk.sv
// Reply stream checker for the ICMP echo responder: predicts each reply byte and compares.
`timescale 1ns / 1ps
module icmp_echo_responder_chk #(
  parameter int MAX_FRAME_BYTES = 2048,
  parameter int DELAY_BYTES     = 38
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] frame_byte
  input  logic       in_tlast,   // frame_last
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // [7:0] out_byte
  input  logic       out_tlast,  // out_last
  input  logic [2:0] out_tuser,  // [0] keep_frame, [2:1] verdict
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,  // [7:0] reply_ttl
  output int         fail_count,
  output int         bytes_due,
  output int         bytes_checked,
  output logic [3:0] verdicts_seen
);
  import ier_pkg::*;

  localparam int IP_SRC       = OFS_CSUM_LO + 1;
  localparam int IP_DST       = IP_SRC + IP_ADDR_BYTES;
  localparam int ICMP_CSUM_HI = OFS_ICMP + 2;

  // shadow of the rewriter
  logic [7:0]  line_buf [DELAY_BYTES];
  int unsigned frame_pos;
  int unsigned wr_ptr;
  logic [15:0] icmp_acc;
  logic [15:0] hdr_acc;
  logic [15:0] total_len;
  logic        echo_req;
  logic [7:0]  ttl_now;
  ier_res_t    reply_due [$];
  int          k;

  function automatic logic [15:0] fold16(input logic [15:0] a, input logic [15:0] b);
    int unsigned t;
    t = 32'(a) + 32'(b);
    t = (t & 32'hFFFF) + (t >> 16);
    return t[15:0];
  endfunction

  task automatic swap_span(input int a, input int b, input int len);
    int i;
    logic [7:0] tmp;
    for (i = 0; i < len; i++) begin
      tmp = line_buf[(a + i) % DELAY_BYTES];
      line_buf[(a + i) % DELAY_BYTES] = line_buf[(b + i) % DELAY_BYTES];
      line_buf[(b + i) % DELAY_BYTES] = tmp;
    end
  endtask

  task automatic clear_frame();
    frame_pos = 0;
    wr_ptr    = 0;
    icmp_acc  = '0;
    hdr_acc   = '0;
    total_len = '0;
    echo_req  = 1'b0;
  endtask

  task automatic rewrite_byte(input logic [7:0] b, input logic fin);
    int unsigned n;
    int unsigned got;
    int unsigned fill;
    int unsigned first;
    int unsigned i;
    logic        counted;
    logic [7:0]  kept;
    logic [15:0] hc;
    logic [15:0] msg;
    logic [15:0] nc;
    verdict_t    vd;
    ier_res_t    rec;
    n       = frame_pos;
    counted = n < MAX_FRAME_BYTES;
    kept    = (n == OFS_TTL) ? ttl_now : b;
    if (counted) begin
      if (n == OFS_TL_HI) total_len = {b, 8'h00};
      if (n == OFS_TL_LO) total_len = total_len | {8'h00, b};
      if (n >= OFS_IP_START && n <= OFS_IP_END && n != OFS_CSUM_HI && n != OFS_CSUM_LO)
        hdr_acc = fold16(hdr_acc, ((n - OFS_IP_START) % 2 == 0) ? {kept, 8'h00} : {8'h00, kept});
      if (n == OFS_ICMP) echo_req = (b == ICMP_ECHO_REQUEST);
      if (n >= OFS_ICMP && total_len >= IP_HDR_BYTES &&
          (n - OFS_ICMP) < 32'(total_len) - IP_HDR_BYTES)
        icmp_acc = fold16(icmp_acc, ((n - OFS_ICMP) % 2 == 0) ? {b, 8'h00} : {8'h00, b});
    end

    // line full: the oldest byte leaves
    if (n >= DELAY_BYTES) begin
      rec.data    = line_buf[wr_ptr];
      rec.last    = 1'b0;
      rec.keep    = 1'b0;
      rec.verdict = VD_REPLY;
      reply_due.push_back(rec);
    end
    line_buf[wr_ptr] = kept;
    wr_ptr = (wr_ptr + 1) % DELAY_BYTES;

    if (n == OFS_ETH_END) swap_span(0, MAC_BYTES, MAC_BYTES);
    if (n == OFS_IP_END) begin
      swap_span(IP_SRC, IP_DST, IP_ADDR_BYTES);
      line_buf[OFS_CSUM_HI] = ~hdr_acc[15:8];
      line_buf[OFS_CSUM_LO] = ~hdr_acc[7:0];
    end
    if (n == OFS_ICMP_HDR_END) begin
      // incremental update: drop the old type/code word, which becomes zero
      hc  = {line_buf[ICMP_CSUM_HI], line_buf[ICMP_CSUM_HI + 1]};
      msg = {line_buf[OFS_ICMP], line_buf[OFS_ICMP + 1]};
      nc  = ~fold16(~hc, ~msg);
      line_buf[OFS_ICMP]         = 8'h00;
      line_buf[OFS_ICMP + 1]     = 8'h00;
      line_buf[ICMP_CSUM_HI]     = nc[15:8];
      line_buf[ICMP_CSUM_HI + 1] = nc[7:0];
    end

    if (counted) frame_pos = n + 1;

    if (fin) begin
      got   = frame_pos;
      fill  = (got < DELAY_BYTES) ? got : DELAY_BYTES;
      first = (got >= DELAY_BYTES) ? wr_ptr : 0;
      if (total_len < MIN_TOTAL_LEN || got < ETH_HDR_BYTES + 32'(total_len)) vd = VD_SHORT;
      else if (icmp_acc != SUM_GOOD) vd = VD_BAD_CSUM;
      else if (!echo_req)            vd = VD_NOT_ECHO;
      else                           vd = VD_REPLY;
      for (i = 0; i < fill; i++) begin
        rec.data    = line_buf[(first + i) % DELAY_BYTES];
        rec.last    = (i + 1 == fill);
        rec.keep    = rec.last && (vd == VD_REPLY);
        rec.verdict = rec.last ? vd : VD_REPLY;
        reply_due.push_back(rec);
      end
      clear_frame();
    end
  endtask

  task automatic report_bad(input string what);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] reply byte %0d: %s", $time, bytes_checked, what);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (k = 0; k < DELAY_BYTES; k++) line_buf[k] = 8'h00;
      clear_frame();
      ttl_now = TTL_RESET;
      reply_due.delete();
      fail_count    = 0;
      bytes_checked = 0;
      verdicts_seen = '0;
    end else begin
      if (cfg_we) ttl_now = cfg_wdata;
      if (in_tvalid && in_tready) rewrite_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (reply_due.size() == 0) begin
          report_bad($sformatf("nothing pending, got data %02h last %0b user %03b",
                               out_tdata, out_tlast, out_tuser));
        end else begin
          ier_res_t want;
          want = reply_due.pop_front();
          if (want.last) verdicts_seen[want.verdict] = 1'b1;
          if (want.data !== out_tdata || want.last !== out_tlast ||
              want.keep !== out_tuser[0] || want.verdict !== out_tuser[2:1])
            report_bad($sformatf({"expected data %02h last %0b keep %0b verdict %0d, ",
                                  "got data %02h last %0b keep %0b verdict %0d"},
                                 want.data, want.last, want.keep, want.verdict,
                                 out_tdata, out_tlast, out_tuser[0], out_tuser[2:1]));
        end
        bytes_checked++;
      end
    end
    bytes_due = reply_due.size();
  end

endmodule

### test/icmp_echo_responder_tb.sv
// Testbench top for the ICMP echo responder: frame stimulus, stall patterns and verdict.
`timescale 1ns / 1ps
module icmp_echo_responder_tb;
  import ier_pkg::*;

  localparam int MAX_BYTES    = 2048;
  localparam int DELAY        = 38;
  localparam int RANDOM_BYTES = 40;          // random part stops once this many bytes went in
  localparam int LONG_HOLD    = 300;         // receiver hold-off, in cycles
  localparam int SETTLE       = 2 * DELAY + 8;
  localparam int QUIET_LIMIT  = 2000;        // cycles with no request moving on either side

  localparam logic [7:0] IPV4_HI      = 8'h08;  // ethertype 0x0800
  localparam logic [7:0] IPV4_LO      = 8'h00;
  localparam logic [7:0] VER_IHL      = 8'h45;
  localparam logic [7:0] PROTO_ICMP   = 8'h01;
  localparam int         ICMP_HDR_LEN = 8;

  // what kind of frame to build
  typedef enum int {
    FR_ECHO,      // well-formed echo request
    FR_BAD_SUM,   // one bit flipped inside the ICMP message
    FR_NOT_ECHO,  // valid checksum, type other than echo request
    FR_CUT,       // frame ends before the IP length says
    FR_LEN_LOW,   // IP length below the 28-byte minimum
    FR_ZERO_MSG,  // ICMP message all zero: sum never reaches 0xFFFF
    FR_NOISE      // random bytes
  } frame_kind_t;

  // receiver stall behavior, picked anew at random intervals
  typedef enum int {RX_OPEN, RX_COIN, RX_ONE_IN_FOUR, RX_MOSTLY} rx_mode_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] frame_byte
  logic       in_tlast;   // frame_last
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [7:0] out_byte
  logic       out_tlast;  // out_last
  logic [2:0] out_tuser;  // [0] keep_frame, [2:1] verdict
  logic       cfg_we;
  logic [7:0] cfg_wdata;  // [7:0] reply_ttl

  int         fail_count;
  int         bytes_due;
  int         bytes_checked;
  logic [3:0] verdicts_seen;

  logic [7:0] frame_buf [$];
  int         frames_sent = 0;
  int         bytes_sent  = 0;
  int         ttl_writes  = 0;
  int         burst_left  = 0;
  int         quiet       = 0;
  bit         hold_req    = 1'b0;

  always #5 clk = ~clk;

  icmp_echo_responder #(
    .MAX_FRAME_BYTES(MAX_BYTES),
    .DELAY_BYTES    (DELAY)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  icmp_echo_responder_chk #(
    .MAX_FRAME_BYTES(MAX_BYTES),
    .DELAY_BYTES    (DELAY)
  ) chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .out_tuser    (out_tuser),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .bytes_due    (bytes_due),
    .bytes_checked(bytes_checked),
    .verdicts_seen(verdicts_seen)
  );

  // Watchdog: a run that stops moving requests is a failure.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet == QUIET_LIMIT) begin
      $display("icmp_echo_responder test failed");
      $finish;
    end
  end

  // Receiver: stall modes switch at random intervals; on request one long hold-off
  // so the delay line backs up and the block stops taking bytes.
  initial begin : rx_side
    rx_mode_t mode;
    int       left;
    int       held;
    out_tready = 1'b0;
    mode = RX_OPEN;
    left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 1'b0;
        for (held = 0; held < LONG_HOLD; held++) @(negedge clk);
        hold_req = 1'b0;
      end
      if (left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        left = $urandom_range(8, 80);
      end
      left--;
      case (mode)
        RX_OPEN:        out_tready = 1'b1;
        RX_COIN:        out_tready = 1'($urandom_range(0, 1));
        RX_ONE_IN_FOUR: out_tready = (left % 4 == 0);
        default:        out_tready = ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  // Builds one frame into frame_buf. pay_len is the echo data length after the
  // 8-byte ICMP header (or the whole length for noise), pad_len trailing bytes.
  task automatic build_frame(input frame_kind_t kind, input int pay_len, input int pad_len);
    logic [15:0] ip_len;
    logic [15:0] csum;
    logic [7:0]  msg_kind;
    int unsigned acc;
    int          i;
    int          cut_to;
    frame_buf.delete();
    if (kind == FR_NOISE) begin
      for (i = 0; i < pay_len; i++) frame_buf.push_back(rnd8());
      return;
    end
    ip_len = 16'(IP_HDR_BYTES + ICMP_HDR_LEN + pay_len);
    if (kind == FR_LEN_LOW) ip_len = 16'($urandom_range(0, MIN_TOTAL_LEN - 1));

    // Ethernet: two MACs and the IPv4 ethertype
    for (i = 0; i < 2 * MAC_BYTES; i++) frame_buf.push_back(rnd8());
    frame_buf.push_back(IPV4_HI);
    frame_buf.push_back(IPV4_LO);
    // IP header: version/IHL, TOS, length, id+flags, TTL, protocol, checksum, addresses
    frame_buf.push_back(VER_IHL);
    frame_buf.push_back(rnd8());
    frame_buf.push_back(ip_len[15:8]);
    frame_buf.push_back(ip_len[7:0]);
    for (i = 0; i < 5; i++) frame_buf.push_back(rnd8());
    frame_buf.push_back(PROTO_ICMP);
    for (i = 0; i < 2 + 2 * IP_ADDR_BYTES; i++) frame_buf.push_back(rnd8());

    // ICMP header and echo data
    if (kind == FR_NOT_ECHO) begin
      do msg_kind = rnd8(); while (msg_kind == ICMP_ECHO_REQUEST);
    end else begin
      msg_kind = ICMP_ECHO_REQUEST;
    end
    frame_buf.push_back(msg_kind);
    frame_buf.push_back(($urandom_range(0, 3) == 0) ? rnd8() : 8'h00);
    for (i = 2; i < ICMP_HDR_LEN + pay_len; i++) frame_buf.push_back(rnd8());

    if (kind == FR_ZERO_MSG) begin
      for (i = OFS_ICMP; i < frame_buf.size(); i++) frame_buf[i] = 8'h00;
    end else begin
      frame_buf[OFS_ICMP + 2] = 8'h00;
      frame_buf[OFS_ICMP + 3] = 8'h00;
      acc = 0;
      for (i = OFS_ICMP; i < frame_buf.size(); i++)
        acc += ((i - OFS_ICMP) % 2 == 0) ? 32'({frame_buf[i], 8'h00}) : 32'(frame_buf[i]);
      while (acc > 32'hFFFF) acc = (acc & 32'hFFFF) + (acc >> 16);
      csum = ~acc[15:0];
      frame_buf[OFS_ICMP + 2] = csum[15:8];
      frame_buf[OFS_ICMP + 3] = csum[7:0];
    end
    if (kind == FR_BAD_SUM) begin
      i = $urandom_range(OFS_ICMP, frame_buf.size() - 1);
      frame_buf[i] = frame_buf[i] ^ 8'(1 << $urandom_range(0, 7));
    end

    // trailing padding past the IP length, never summed
    for (i = 0; i < pad_len; i++) frame_buf.push_back(rnd8());

    if (kind == FR_CUT) begin
      cut_to = $urandom_range(1, ETH_HDR_BYTES + 32'(ip_len) - 1);
      while (frame_buf.size() > cut_to) void'(frame_buf.pop_back());
    end
  endtask

  // Offers frame_buf one request at a time. Bursts of random length, with
  // random gaps between them; some bursts run long with no idling at all.
  task automatic send_frame();
    int i;
    for (i = 0; i < frame_buf.size(); i++) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                 : $urandom_range(1, 20);
        if ($urandom_range(0, 2) != 0) begin
          in_tvalid = 1'b0;
          repeat ($urandom_range(1, 8)) @(negedge clk);
        end
      end
      burst_left--;
      in_tvalid = 1'b1;
      in_tdata  = frame_buf[i];
      in_tlast  = (i == frame_buf.size() - 1);
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      @(negedge clk);
    end
    frames_sent++;
    bytes_sent += frame_buf.size();
  endtask

  // Sender goes quiet until every predicted reply byte is out, then gives the
  // drain pass a further SETTLE period.
  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (bytes_due != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // TTL only changes between frames with the block idle
  task automatic set_ttl(input logic [7:0] ttl);
    wait_drained();
    cfg_we    = 1'b1;
    cfg_wdata = ttl;
    @(negedge clk);
    cfg_we    = 1'b0;
    ttl_writes++;
  endtask

  initial begin : stimulus
    int          rand_bytes;
    int          frame_no;
    int          pick;
    frame_kind_t kind;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tlast  = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = 8'h00;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed frames, TTL still at its reset value. The receiver holds off
    // during the first one so the line backs up and the input stalls.
    hold_req = 1'b1;
    build_frame(FR_ECHO, 0, 1);           // minimal echo, IP length 28, one pad byte
    send_frame();
    build_frame(FR_ZERO_MSG, 0, 0);       // all-zero message fails the sum
    send_frame();
    build_frame(FR_NOISE, 1, 0);          // single-byte frame
    send_frame();
    build_frame(FR_NOISE, DELAY + 1, 0);  // one byte past the line length
    send_frame();

    // TTL extremes
    set_ttl(8'h00);
    build_frame(FR_NOT_ECHO, 1, 2);       // odd message length, trailing pad
    send_frame();
    set_ttl(8'hFF);
    build_frame(FR_ECHO, 0, 0);
    send_frame();

    // Random frames: on average half well-formed echo requests, the rest broken ones.
    rand_bytes = 0;
    frame_no   = 0;
    while (rand_bytes < RANDOM_BYTES) begin
      if (frame_no % 3 == 2) set_ttl(rnd8());
      if (frame_no == 4) wait_drained();
      pick = $urandom_range(0, 9);
      case (pick)
        5:       kind = FR_BAD_SUM;
        6:       kind = FR_NOT_ECHO;
        7:       kind = FR_CUT;
        8:       kind = FR_LEN_LOW;
        9:       kind = FR_NOISE;
        default: kind = FR_ECHO;
      endcase
      build_frame(kind, (kind == FR_NOISE) ? $urandom_range(1, 40) : $urandom_range(0, 8),
                  ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0);
      send_frame();
      rand_bytes += frame_buf.size();
      frame_no++;
    end

    wait_drained();
    $display("%0d frames, %0d request bytes in, %0d reply bytes checked, %0d TTL settings",
             frames_sent, bytes_sent, bytes_checked, ttl_writes + 1);
    $display("verdicts hit: reply %0b, bad checksum %0b, not echo %0b, too short %0b",
             verdicts_seen[VD_REPLY], verdicts_seen[VD_BAD_CSUM],
             verdicts_seen[VD_NOT_ECHO], verdicts_seen[VD_SHORT]);
    if (fail_count == 0 && bytes_due == 0) begin
      $display("icmp_echo_responder test passed");
    end else begin
      $display("icmp_echo_responder test failed");
    end
    $finish;
  end

endmodule
